>>> rtl/aiffhp_pkg.sv
// ----------------------------------------------------------------------------
// AIFF header parser package
// Phase and status codes, chunk tags and extended-float constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aiffhp_pkg;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_CHUNK,
    PH_COMM_FMT,
    PH_COMM_RATE,
    PH_SKIP,
    PH_PAD
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_NOT_AIFF,
    ST_BAD_COMM_LEN,
    ST_UNSUPPORTED,
    ST_TRUNCATED
  } status_e;

  localparam logic [31:0] TAG_FORM = 32'h464F_524D;
  localparam logic [31:0] TAG_AIFF = 32'h4149_4646;
  localparam logic [31:0] TAG_COMM = 32'h434F_4D4D;
  localparam logic [31:0] TAG_SSND = 32'h5353_4E44;
  localparam logic [31:0] COMM_LEN = 32'd18;

  localparam int unsigned EXP_BIAS       = 16383;
  localparam int unsigned MANT_FRAC_BITS = 63;
  localparam logic [14:0] EXP_SPECIAL    = 15'h7FFF;
  localparam logic [14:0] EXP_INT_ZERO   = 15'(EXP_BIAS + MANT_FRAC_BITS);

endpackage

>>> rtl/aiff_header_parser_unit.sv
// ----------------------------------------------------------------------------
// AIFF header parser unit
// Walks the FORM/AIFF chunk list one byte per word, reads COMM, and reports
// status, format fields and audio start offset once per file.
// ----------------------------------------------------------------------------
// An accepted byte passes through the input register, and its result through the result register.
// Throughput: one byte per cycle unless a result waits on a stalled output; the parser
// state register closes its loop combinationally, the result register decouples the output stall.
// Reset: parser state, input register and result valid cleared; the first bytes
// after reset are parsed as the start of a file.
`timescale 1ns / 1ps

module aiff_header_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  file_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [1:0]  channels_o,
  output logic [31:0] frame_count_o,
  output logic [4:0]  sample_bits_o,
  output logic [2:0]  frame_bytes_o,
  output logic signed [31:0] sample_rate_o,
  output logic [31:0] audio_offset_o
);
  import aiffhp_pkg::*;

  function automatic logic [31:0] rate_to_int(logic [15:0] se, logic [63:0] m);
    logic        neg;
    logic [14:0] ex;
    logic [14:0] sh_l;
    logic [14:0] sh_r;
    logic [63:0] mag;
    logic        sat;
    logic [31:0] res;
    neg  = se[15];
    ex   = se[14:0];
    sh_l = ex - EXP_INT_ZERO;
    sh_r = EXP_INT_ZERO - ex;
    mag  = '0;
    sat  = 1'b0;
    if (ex == EXP_SPECIAL) begin
      sat = 1'b1;
    end else if (m != '0) begin
      if (ex >= EXP_INT_ZERO) begin
        if (sh_l >= 15'd32 || m[63:32] != '0) begin
          sat = 1'b1;
        end else begin
          mag = {32'd0, m[31:0]} << sh_l[4:0];
        end
      end else if (sh_r < 15'd64) begin
        mag = m >> sh_r[5:0];
      end
      if (mag > 64'h0000_0000_8000_0000) begin
        sat = 1'b1;
      end
    end
    if (neg) begin
      if (sat || mag >= 64'h0000_0000_8000_0000) begin
        res = 32'h8000_0000;
      end else begin
        res = 32'd0 - mag[31:0];
      end
    end else begin
      if (sat || mag > 64'h0000_0000_7FFF_FFFF) begin
        res = 32'h7FFF_FFFF;
      end else begin
        res = mag[31:0];
      end
    end
    return res;
  endfunction

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       first_q;
  logic       last_q;

  // parser state
  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] len_q, len_d;
  logic [31:0] skip_q, skip_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] frames_q, frames_d;
  logic [15:0] depth_q, depth_d;
  logic [15:0] sexp_q, sexp_d;
  logic [63:0] mant_q, mant_d;
  logic [31:0] pos_q, pos_d;
  logic        fin_q, fin_d;
  logic        comm_q, comm_d;

  // result register
  logic        out_valid_q;
  status_e     status_q;
  logic [1:0]  chan_out_q;
  logic [31:0] frames_out_q;
  logic [4:0]  bits_out_q;
  logic [2:0]  fb_out_q;
  logic [31:0] rate_out_q;
  logic [31:0] offset_out_q;

  logic        res_fire;
  status_e     res_status;
  logic        has_status;
  logic        fin_base;
  logic [5:0]  fb_prod;
  logic        out_free;
  logic        advance;
  logic        in_accept;

  always_comb begin
    if (first_q) begin
      phase_d  = PH_HEADER;
      cnt_d    = '0;
      tag_d    = '0;
      len_d    = '0;
      skip_d   = '0;
      chan_d   = '0;
      frames_d = '0;
      depth_d  = '0;
      sexp_d   = '0;
      mant_d   = '0;
      pos_d    = '0;
      fin_base = 1'b0;
      comm_d   = 1'b0;
    end else begin
      phase_d  = phase_q;
      cnt_d    = cnt_q;
      tag_d    = tag_q;
      len_d    = len_q;
      skip_d   = skip_q;
      chan_d   = chan_q;
      frames_d = frames_q;
      depth_d  = depth_q;
      sexp_d   = sexp_q;
      mant_d   = mant_q;
      pos_d    = pos_q;
      fin_base = fin_q;
      comm_d   = comm_q;
    end
    has_status = 1'b0;
    res_status = ST_OK;

    if (!fin_base) begin
      pos_d = pos_d + 32'd1;
      case (phase_d)
        PH_HEADER: begin
          if (cnt_d < 4'd4 || cnt_d >= 4'd8) begin
            tag_d = {tag_d[23:0], byte_q};
          end else begin
            len_d = {len_d[23:0], byte_q};
          end
          if (cnt_d == 4'd3 && tag_d != TAG_FORM) begin
            has_status = 1'b1;
            res_status = ST_NOT_AIFF;
          end else if (cnt_d >= 4'd11) begin
            if (tag_d != TAG_AIFF) begin
              has_status = 1'b1;
              res_status = ST_NOT_AIFF;
            end else begin
              phase_d = PH_CHUNK;
              cnt_d   = '0;
            end
          end else begin
            cnt_d = cnt_d + 4'd1;
          end
        end
        PH_CHUNK: begin
          if (cnt_d < 4'd4) begin
            tag_d = {tag_d[23:0], byte_q};
          end else begin
            len_d = {len_d[23:0], byte_q};
          end
          if (cnt_d >= 4'd7) begin
            cnt_d = '0;
            if (tag_d == TAG_SSND) begin
              has_status = 1'b1;
              res_status = ST_OK;
            end else if (tag_d == TAG_COMM) begin
              if (len_d != COMM_LEN) begin
                has_status = 1'b1;
                res_status = ST_BAD_COMM_LEN;
              end else begin
                comm_d  = 1'b0;
                phase_d = PH_COMM_FMT;
              end
            end else if (len_d != '0) begin
              skip_d  = len_d;
              phase_d = PH_SKIP;
            end
          end else begin
            cnt_d = cnt_d + 4'd1;
          end
        end
        PH_COMM_FMT: begin
          if (cnt_d < 4'd2) begin
            chan_d = {chan_d[7:0], byte_q};
          end else if (cnt_d < 4'd6) begin
            frames_d = {frames_d[23:0], byte_q};
          end else begin
            depth_d = {depth_d[7:0], byte_q};
          end
          if (cnt_d >= 4'd7) begin
            cnt_d = '0;
            if (!(chan_d == 16'd1 || chan_d == 16'd2) ||
                !(depth_d == 16'd8 || depth_d == 16'd16)) begin
              has_status = 1'b1;
              res_status = ST_UNSUPPORTED;
            end else begin
              phase_d = PH_COMM_RATE;
            end
          end else begin
            cnt_d = cnt_d + 4'd1;
          end
        end
        PH_COMM_RATE: begin
          if (cnt_d < 4'd2) begin
            sexp_d = {sexp_d[7:0], byte_q};
          end else begin
            mant_d = {mant_d[55:0], byte_q};
          end
          if (cnt_d >= 4'd9) begin
            cnt_d   = '0;
            comm_d  = 1'b1;
            phase_d = PH_CHUNK;
          end else begin
            cnt_d = cnt_d + 4'd1;
          end
        end
        PH_SKIP: begin
          if (skip_d != '0) begin
            skip_d = skip_d - 32'd1;
          end
          if (skip_d == '0) begin
            cnt_d   = '0;
            phase_d = len_d[0] ? PH_PAD : PH_CHUNK;
          end
        end
        default: begin
          cnt_d   = '0;
          phase_d = PH_CHUNK;
        end
      endcase
      if (!has_status && last_q) begin
        has_status = 1'b1;
        res_status = ST_TRUNCATED;
      end
    end

    res_fire = !fin_base && has_status;
    fin_d    = fin_base || res_fire;
    fb_prod  = {3'd0, chan_d[2:0]} * {3'd0, depth_d[5:3]};
  end

  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (out_free || !res_fire);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      byte_q     <= '0;
      first_q    <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_q <= 1'b1;
        byte_q     <= file_byte_i;
        first_q    <= first_byte_i;
        last_q     <= last_byte_i;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      cnt_q    <= '0;
      tag_q    <= '0;
      len_q    <= '0;
      skip_q   <= '0;
      chan_q   <= '0;
      frames_q <= '0;
      depth_q  <= '0;
      sexp_q   <= '0;
      mant_q   <= '0;
      pos_q    <= '0;
      fin_q    <= 1'b0;
      comm_q   <= 1'b0;
    end else if (advance) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      tag_q    <= tag_d;
      len_q    <= len_d;
      skip_q   <= skip_d;
      chan_q   <= chan_d;
      frames_q <= frames_d;
      depth_q  <= depth_d;
      sexp_q   <= sexp_d;
      mant_q   <= mant_d;
      pos_q    <= pos_d;
      fin_q    <= fin_d;
      comm_q   <= comm_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_fire) begin
      status_q     <= res_status;
      chan_out_q   <= comm_d ? chan_d[1:0] : 2'd0;
      frames_out_q <= comm_d ? frames_d : 32'd0;
      bits_out_q   <= comm_d ? depth_d[4:0] : 5'd0;
      fb_out_q     <= comm_d ? fb_prod[2:0] : 3'd0;
      rate_out_q   <= comm_d ? rate_to_int(sexp_d, mant_d) : 32'd0;
      offset_out_q <= (res_status == ST_OK) ? pos_d : 32'd0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign channels_o     = chan_out_q;
  assign frame_count_o  = frames_out_q;
  assign sample_bits_o  = bits_out_q;
  assign frame_bytes_o  = fb_out_q;
  assign sample_rate_o  = rate_out_q;
  assign audio_offset_o = offset_out_q;

endmodule
